>>> design/next_fit_channel_allocator_assert.svh
// Assertion macros used by the allocator's checker.
`ifndef NEXT_FIT_CHANNEL_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_CHANNEL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define NFCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define NFCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/nfca_pkg.sv
// Package: constants, state type and helper of the next-fit channel allocator.
package nfca_pkg;

  localparam int NUM_CHANNELS_DEF = 128;
  localparam int CHANNEL_W        = 7;
  localparam int WORD_BITS        = 8;
  localparam int WORD_OFF_W       = 3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_SCAN
  } state_t;

  // Position of the lowest set bit; zero when none is set.
  function automatic logic [WORD_OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_OFF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/next_fit_channel_allocator.sv
// Top level: next-fit channel allocator over a busy bitmap held in a word memory.
//
// Usage
//   Command channel: present op and channel with start high; the word is taken at a
//   rising edge where start is high and busy is low. op = allocate ignores channel;
//   op = release frees the named channel (a number at or above NUM_CHANNELS is ignored).
//   Result channel: done is high for exactly one cycle with granted and channel_out.
//   The receiver cannot stall; every result must be taken in its one cycle.
// Timing
//   The bitmap sits in a memory of eight-channel rows, one row read per cycle, and a
//   single scan unit masks the row and picks its lowest free channel.
//   Release: the row is read into rd_data, then cleared in ST_REL and done registered
//   (an ignored channel is answered straight from idle). Allocate: ST_SCAN masks each
//   row in turn from the start row, until one has a free channel or the start row is
//   reached again, and answers with no grant when every channel is busy.
//   busy drops in the cycle that done is shown, so the next word can go in then.
// Reset
//   rst (synchronous) frees every channel through per-row valid bits, clears the
//   last-granted channel to 0 and returns the sequencer to idle; no sweep is needed.
module next_fit_channel_allocator import nfca_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [CHANNEL_W-1:0] channel,
  output logic                 done,
  output logic                 granted,
  output logic [CHANNEL_W-1:0] channel_out
);

  localparam int NUM_WORDS = (NUM_CHANNELS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CH_W      = $clog2(NUM_CHANNELS);
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);

  // Sequencer registers
  state_t                state, state_next;
  logic [CNT_W-1:0]      visit, visit_next;        // rows examined so far in this scan
  logic [WA_W-1:0]       word_addr, word_addr_next; // row whose data is now in rd_data
  logic [WORD_OFF_W-1:0] bit_sel, bit_sel_next;    // scan start offset, or release bit
  logic [CH_W-1:0]       last_granted, last_next;
  logic                  done_next, granted_next;
  logic [CHANNEL_W-1:0]  channel_out_next;

  // Bitmap memory: one row of eight busy flags per entry, valid bits stand for reset
  logic [WORD_BITS-1:0]  mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]  row_valid;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  rd_ok;
  logic [WA_W-1:0]       rd_addr;
  logic                  wr_en;
  logic [WORD_BITS-1:0]  wr_data;

  // Scan unit signals
  logic [WORD_BITS-1:0]  row;
  logic [WORD_BITS-1:0]  cand;
  logic                  hit;
  logic [WORD_OFF_W-1:0] hit_bit;
  logic [CH_W-1:0]       found_pos;
  logic [CH_W-1:0]       start_pos;
  logic [WA_W-1:0]       addr_inc;
  logic                  rel_in_range;

  assign busy = (state != ST_IDLE);

  // Start one past the last grant, wrapping the top channel to zero
  assign start_pos = (last_granted == CH_W'(NUM_CHANNELS - 1)) ? '0 : last_granted + 1'b1;
  assign addr_inc  = (word_addr == WA_W'(NUM_WORDS - 1)) ? '0 : word_addr + 1'b1;
  assign rel_in_range = (int'(channel) < NUM_CHANNELS);

  // An unwritten row reads as all free
  assign row = rd_ok ? rd_data : '0;

  // Mask the row: in range, and on the first visit the part at or above the start,
  // on the closing visit of the start row only the part below it
  always_comb begin
    logic [WA_W+WORD_OFF_W-1:0] gidx;
    logic                       window;
    for (int b = 0; b < WORD_BITS; b++) begin
      gidx = {word_addr, WORD_OFF_W'(b)};
      if (visit == '0) begin
        window = (WORD_OFF_W'(b) >= bit_sel);
      end else if (visit == CNT_W'(NUM_WORDS)) begin
        window = (WORD_OFF_W'(b) < bit_sel);
      end else begin
        window = 1'b1;
      end
      cand[b] = ~row[b] & window & (int'(gidx) < NUM_CHANNELS);
    end
  end

  assign hit       = |cand;
  assign hit_bit   = lowest_set(cand);
  assign found_pos = CH_W'({word_addr, hit_bit});

  // Next state and datapath control
  always_comb begin
    state_next       = state;
    visit_next       = visit;
    word_addr_next   = word_addr;
    bit_sel_next     = bit_sel;
    last_next        = last_granted;
    rd_addr          = word_addr;
    wr_en            = 1'b0;
    wr_data          = row;
    done_next        = 1'b0;
    granted_next     = 1'b0;
    channel_out_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_RELEASE) begin
            if (rel_in_range) begin
              word_addr_next = WA_W'(channel >> WORD_OFF_W);
              bit_sel_next   = WORD_OFF_W'(channel);
              rd_addr        = WA_W'(channel >> WORD_OFF_W);
              state_next     = ST_REL;
            end else begin
              // drop the release, answer at once
              done_next = 1'b1;
            end
          end else begin
            word_addr_next = WA_W'(start_pos >> WORD_OFF_W);
            bit_sel_next   = WORD_OFF_W'(start_pos);
            visit_next     = '0;
            rd_addr        = WA_W'(start_pos >> WORD_OFF_W);
            state_next     = ST_SCAN;
          end
        end
      end
      ST_REL: begin
        wr_en      = 1'b1;
        wr_data    = row & ~(WORD_BITS'(1) << bit_sel);
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit) begin
          wr_en            = 1'b1;
          wr_data          = row | (WORD_BITS'(1) << hit_bit);
          last_next        = found_pos;
          done_next        = 1'b1;
          granted_next     = 1'b1;
          channel_out_next = CHANNEL_W'(found_pos);
          state_next       = ST_IDLE;
        end else if (visit == CNT_W'(NUM_WORDS)) begin
          // every channel busy: answer with no grant
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          visit_next     = visit + 1'b1;
          word_addr_next = addr_inc;
          rd_addr        = addr_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_granted <= '0;
      done         <= 1'b0;
      row_valid    <= '0;
    end else begin
      state        <= state_next;
      last_granted <= last_next;
      done         <= done_next;
      if (wr_en) begin
        row_valid[word_addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    visit       <= visit_next;
    word_addr   <= word_addr_next;
    bit_sel     <= bit_sel_next;
    granted     <= granted_next;
    channel_out <= channel_out_next;
  end

  // Bitmap memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_ok   <= row_valid[rd_addr];
  end

endmodule

>>> design/nfca_checker.sv
// Checker of the allocator's port behaviour, bound to the top level.
`include "next_fit_channel_allocator_assert.svh"

module nfca_checker import nfca_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 op,
  input logic                 done,
  input logic                 granted,
  input logic [CHANNEL_W-1:0] channel_out
);

  `NFCA_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")
  `NFCA_ASSERT_IMP(a_no_grant_zero, done && !granted, channel_out == '0, "channel without grant")
  `NFCA_ASSERT_IMP(a_fall_gives_done, $fell(busy), done, "busy dropped with no result")
  `NFCA_ASSERT_NXT(a_alloc_busy, start && !busy && op == OP_ALLOC, busy, "allocate not taken up")
  `NFCA_ASSERT_NXT(a_release_path, start && !busy && op == OP_RELEASE,
                   busy || (done && !granted), "release answered wrongly")

endmodule

bind next_fit_channel_allocator nfca_checker u_nfca_checker (.*);
